/* rtl/core/ffd_pkg.sv */
package ffd_pkg;

    localparam int PAYLOAD_BYTES = 8;
    localparam int PAYLOAD_W     = 64;
    localparam int BYTE_W        = 8;
    localparam int POS_W         = 4;
    localparam int IDX_W         = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
    localparam int CFG_IDX_W     = 8;

    localparam logic [POS_W-1:0] POS_HUNT = POS_W'(0);
    localparam logic [POS_W-1:0] POS_SUM  = POS_W'(PAYLOAD_BYTES + 1);
    localparam logic [POS_W-1:0] POS_END  = POS_W'(PAYLOAD_BYTES + 2);

    localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'hAA;
    localparam logic [BYTE_W-1:0] END_MARKER_RST   = 8'h55;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_MARKER = 8'd0,
        REG_END_MARKER   = 8'd1
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_END = 2'd1,
        ST_BAD_SUM = 2'd2
    } t_status;

    typedef struct packed {
        logic [BYTE_W-1:0] start_marker;
        logic [BYTE_W-1:0] end_marker;
    } t_markers;

endpackage

/* rtl/core/ffd_ifs.sv */
interface ffd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ffd_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  frame_status;
    logic [63:0] payload;
    logic [7:0]  computed_checksum;
    logic [7:0]  received_checksum;

    modport source (output valid, output frame_status, output payload,
                    output computed_checksum, output received_checksum, input ready);
    modport sink   (input valid, input frame_status, input payload,
                    input computed_checksum, input received_checksum, output ready);
endinterface

interface ffd_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/fixed_frame_deframer_xor_check.sv */
// Channel  | Dir | Handshake     | Payload
// i_rx     | in  | valid/ready   | rx_byte[7:0]
// o_res    | out | valid/ready   | frame_status[1:0], payload[63:0],
//          |     |               | computed_checksum[7:0], received_checksum[7:0]
// i_cfg    | in  | valid/ready=1 | index[7:0], data[7:0]
//
// One byte accepted per cycle while i_rx.ready is high; a byte is registered on
// acceptance and processed from that register, which also loads the result register
// for an end byte; o_res.valid rises once the end byte is processed.
// Reset is synchronous, active low; markers return to 0xAA and 0x55, hunting.
// i_rx.ready drops only when an end byte is waiting and the result register is
// still held by an untaken result.
module fixed_frame_deframer_xor_check (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ffd_byte_if.sink     i_rx,
    ffd_result_if.source o_res,
    ffd_cfg_if.sink      i_cfg
);
    import ffd_pkg::*;

    t_markers markers;

    ffd_cfg_regs u_cfg_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (i_cfg),
        .o_markers (markers)
    );

    ffd_engine u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_markers (markers),
        .i_rx      (i_rx),
        .o_res     (o_res)
    );

endmodule

/* rtl/core/ffd_cfg_regs.sv */
module ffd_cfg_regs (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ffd_cfg_if.sink         i_cfg,
    output ffd_pkg::t_markers o_markers
);
    import ffd_pkg::*;

    t_markers r_markers;
    logic     cfg_fire;

    assign i_cfg.ready = 1'b1;
    assign cfg_fire    = i_cfg.valid & i_cfg.ready;
    assign o_markers   = r_markers;

    // Indexes beyond the register list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_markers.start_marker <= START_MARKER_RST;
            r_markers.end_marker   <= END_MARKER_RST;
        end else if (cfg_fire) begin
            unique case (i_cfg.index)
                REG_START_MARKER: r_markers.start_marker <= i_cfg.data;
                REG_END_MARKER:   r_markers.end_marker   <= i_cfg.data;
                default: ;
            endcase
        end
    end

endmodule

/* rtl/core/ffd_engine.sv */
module ffd_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ffd_pkg::t_markers i_markers,
    ffd_byte_if.sink          i_rx,
    ffd_result_if.source      o_res
);
    import ffd_pkg::*;

    // input register
    logic              r_s1_valid;
    logic [BYTE_W-1:0] r_s1_byte;

    // frame state
    logic [POS_W-1:0]     r_pos;
    logic [POS_W-1:0]     n_pos;
    logic [BYTE_W-1:0]    r_xor;
    logic [PAYLOAD_W-1:0] r_payload;
    logic [BYTE_W-1:0]    r_sum;

    // result register
    logic                 r_out_valid;
    t_status              r_out_status;
    logic [PAYLOAD_W-1:0] r_out_payload;
    logic [BYTE_W-1:0]    r_out_comp;
    logic [BYTE_W-1:0]    r_out_recv;

    logic             is_hunt;
    logic             is_payload;
    logic             is_sum;
    logic             is_end;
    logic             out_free;
    logic             stall;
    logic             s1_fire;
    logic             rx_fire;
    logic [POS_W-1:0] pos_m1;
    logic [IDX_W-1:0] byte_idx;
    t_status          status;

    assign is_hunt    = (r_pos == POS_HUNT);
    assign is_payload = !is_hunt && (r_pos < POS_SUM);
    assign is_sum     = (r_pos == POS_SUM);
    assign is_end     = !is_hunt && !is_payload && !is_sum;

    assign out_free = !r_out_valid || o_res.ready;
    // hold the byte only when it closes a frame and the result slot is full
    assign stall    = r_s1_valid && is_end && !out_free;
    assign s1_fire  = r_s1_valid && !stall;

    assign i_rx.ready = !stall;
    assign rx_fire    = i_rx.valid && i_rx.ready;

    assign pos_m1   = r_pos - POS_W'(1);
    assign byte_idx = pos_m1[IDX_W-1:0];

    // end marker check takes priority over checksum
    always_comb begin
        if (r_s1_byte != i_markers.end_marker) begin
            status = ST_BAD_END;
        end else if (r_xor != r_sum) begin
            status = ST_BAD_SUM;
        end else begin
            status = ST_OK;
        end
    end

    always_comb begin
        n_pos = r_pos;
        if (is_hunt) begin
            if (r_s1_byte == i_markers.start_marker) begin
                n_pos = POS_W'(1);
            end
        end else if (is_end) begin
            n_pos = POS_HUNT;
        end else begin
            n_pos = r_pos + POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (rx_fire) begin
            r_s1_valid <= 1'b1;
        end else if (!stall) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rx_fire) begin
            r_s1_byte <= i_rx.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_HUNT;
            r_xor <= '0;
        end else if (s1_fire) begin
            r_pos <= n_pos;
            if (is_payload) begin
                r_xor <= r_xor ^ r_s1_byte;
            end else if (is_end || (is_hunt && n_pos != POS_HUNT)) begin
                r_xor <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            if (is_hunt && n_pos != POS_HUNT) begin
                r_payload <= '0;
            end else if (is_payload) begin
                r_payload[BYTE_W*byte_idx +: BYTE_W] <= r_s1_byte;
            end
            if (is_sum) begin
                r_sum <= r_s1_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && is_end) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && is_end) begin
            r_out_status  <= status;
            r_out_payload <= r_payload;
            r_out_comp    <= r_xor;
            r_out_recv    <= r_sum;
        end
    end

    assign o_res.valid             = r_out_valid;
    assign o_res.frame_status      = r_out_status;
    assign o_res.payload           = r_out_payload;
    assign o_res.computed_checksum = r_out_comp;
    assign o_res.received_checksum = r_out_recv;

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_END)
        else $error("frame position out of range");

    a_end_to_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && is_end) |=> (r_pos == POS_HUNT && r_out_valid))
        else $error("frame close did not return to hunting with a result");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stall |-> (r_out_valid && !o_res.ready))
        else $error("input stalled while result slot free");

    a_hunt_xor_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_hunt |-> (r_xor == '0))
        else $error("checksum accumulator not clear while hunting");

endmodule

/* tb/sv/fixed_frame_deframer_xor_check_tb.sv */
module fixed_frame_deframer_xor_check_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ffd_pkg::*;

    localparam int RANDOM_ITEMS   = 1350;
    localparam int FRAMES_PER_RUN = 12;
    localparam int SETTLE_CYCLES  = 6;
    localparam int HOLD_CYCLES    = 400;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int MAX_REPORTS    = 10;

    // indexes past the two marker registers; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOP   = 8'hFF;

    typedef enum int {FRAME_GOOD, FRAME_BAD_END, FRAME_BAD_SUM, FRAME_BAD_BOTH} t_frame_kind;
    typedef enum int {SINK_OPEN, SINK_COIN, SINK_BEAT, SINK_SLOW} t_sink_mode;

    typedef struct {
        t_status            status;
        logic [PAYLOAD_W-1:0] payload;
        logic [BYTE_W-1:0]    calc_sum;
        logic [BYTE_W-1:0]    rcvd_sum;
    } t_frame_result;

    logic i_clk;
    logic i_rst_n;

    ffd_byte_if   rx_if ();
    ffd_result_if res_if ();
    ffd_cfg_if    cfg_if ();

    fixed_frame_deframer_xor_check dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    // deframer state as the block should hold it
    logic [BYTE_W-1:0]    mk_start = START_MARKER_RST;
    logic [BYTE_W-1:0]    mk_end   = END_MARKER_RST;
    logic [POS_W-1:0]     frame_pos = POS_HUNT;
    logic [BYTE_W-1:0]    run_xor = '0;
    logic [PAYLOAD_W-1:0] frame_payload = '0;
    logic [BYTE_W-1:0]    frame_sum = '0;

    logic [BYTE_W-1:0] rx_backlog[$];
    t_frame_result     pending_frames[$];
    t_frame_result     due;

    int items_queued = 0;
    int mismatches   = 0;
    int cycle_cnt    = 0;
    int burst_left   = 0;
    int gap_left     = 0;
    bit fire;

    int         hold_asks   = 0;
    int         hold_served = 0;
    int         hold_left   = 0;
    int         mode_left   = 0;
    int         beat        = 0;
    t_sink_mode sink_mode   = SINK_OPEN;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("** fixed_frame_deframer_xor_check: FAILED **");
            $finish;
        end
    end

    function automatic void advance_frame(input logic [BYTE_W-1:0] b);
        t_frame_result r;
        if (frame_pos == POS_HUNT) begin
            if (b == mk_start) begin
                frame_payload = '0;
                run_xor       = '0;
                frame_pos     = POS_W'(1);
            end
        end else if (frame_pos <= PAYLOAD_BYTES) begin
            frame_payload |= PAYLOAD_W'(b) << (8 * (int'(frame_pos) - 1));
            run_xor       ^= b;
            frame_pos++;
        end else if (frame_pos == POS_SUM) begin
            frame_sum = b;
            frame_pos++;
        end else begin
            // end marker check wins over the checksum check
            if (b != mk_end) begin
                r.status = ST_BAD_END;
            end else if (run_xor != frame_sum) begin
                r.status = ST_BAD_SUM;
            end else begin
                r.status = ST_OK;
            end
            r.payload  = frame_payload;
            r.calc_sum = run_xor;
            r.rcvd_sum = frame_sum;
            pending_frames.push_back(r);
            frame_pos = POS_HUNT;
            run_xor   = '0;
        end
    endfunction

    function automatic void check_field(input string field, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("mismatch on %s: expected %h, got %h", field, want, got);
            end
        end
    endfunction

    function automatic void push_byte(input logic [BYTE_W-1:0] b);
        rx_backlog.push_back(b);
        items_queued++;
    endfunction

    function automatic void queue_frame(input logic [PAYLOAD_W-1:0] pl, input t_frame_kind kind);
        logic [BYTE_W-1:0] ck;
        logic [BYTE_W-1:0] tail;
        ck = '0;
        push_byte(mk_start);
        for (int i = 0; i < PAYLOAD_BYTES; i++) begin
            push_byte(pl[8*i +: 8]);
            ck ^= pl[8*i +: 8];
        end
        tail = mk_end;
        if (kind == FRAME_BAD_SUM || kind == FRAME_BAD_BOTH) begin
            ck ^= 8'($urandom_range(1, 255));
        end
        if (kind == FRAME_BAD_END || kind == FRAME_BAD_BOTH) begin
            tail ^= 8'($urandom_range(1, 255));
        end
        push_byte(ck);
        push_byte(tail);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        cfg_if.valid <= 1'b1;
        do @(posedge i_clk); while (!(cfg_if.valid && cfg_if.ready));
        if (idx == REG_START_MARKER) begin
            mk_start = val;
        end else if (idx == REG_END_MARKER) begin
            mk_end = val;
        end
        cfg_if.valid <= 1'b0;
        // keep the drop and the next raise on separate edges
        @(posedge i_clk);
    endtask

    // wait until every byte is taken and every frame result is back
    task automatic drain_all();
        do @(posedge i_clk);
        while (rx_backlog.size() != 0 || rx_if.valid || pending_frames.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // byte sender: bursts of random length, random gaps between them
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_if.valid <= 1'b0;
        end else begin
            fire = rx_if.valid && rx_if.ready;
            if (fire) begin
                advance_frame(rx_if.rx_byte);
                void'(rx_backlog.pop_front());
            end
            if (!(rx_if.valid && !fire)) begin
                if (gap_left > 0 || rx_backlog.size() == 0) begin
                    if (gap_left > 0) gap_left--;
                    rx_if.valid <= 1'b0;
                end else begin
                    rx_if.valid   <= 1'b1;
                    rx_if.rx_byte <= rx_backlog[0];
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // result receiver: stall pattern of its own, plus a long hold on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (hold_asks != hold_served) begin
                hold_served = hold_asks;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    sink_mode = t_sink_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 200);
                end else begin
                    mode_left--;
                end
                beat++;
                case (sink_mode)
                    SINK_OPEN: res_if.ready <= 1'b1;
                    SINK_COIN: res_if.ready <= 1'($urandom_range(0, 1));
                    SINK_BEAT: res_if.ready <= (beat % 5) < 2;
                    default:   res_if.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_frames.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("unexpected frame result: status %0d payload %h sums %h/%h",
                             res_if.frame_status, res_if.payload,
                             res_if.computed_checksum, res_if.received_checksum);
                end
            end else begin
                due = pending_frames.pop_front();
                check_field("frame_status", 64'(due.status), 64'(res_if.frame_status));
                check_field("payload", due.payload, res_if.payload);
                check_field("computed_checksum", 64'(due.calc_sum),
                            64'(res_if.computed_checksum));
                check_field("received_checksum", 64'(due.rcvd_sum),
                            64'(res_if.received_checksum));
            end
        end
    end

    initial begin
        logic [PAYLOAD_W-1:0] pl;
        logic [BYTE_W-1:0]    part_xor;
        logic [BYTE_W-1:0]    b;
        int                   phase;
        int                   pick;
        int                   n;

        rx_if.valid   = 1'b0;
        rx_if.rx_byte = '0;
        cfg_if.valid  = 1'b0;
        cfg_if.index  = '0;
        cfg_if.data   = '0;
        res_if.ready  = 1'b0;
        i_rst_n       = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset markers: noise while hunting, markers as data, both errors at once
        push_byte(8'h00);
        push_byte(8'hFF);
        queue_frame(64'hFF00_55AA_0000_FFFF, FRAME_GOOD);
        queue_frame('1, FRAME_BAD_BOTH);

        phase = 0;
        while (items_queued < RANDOM_ITEMS + 24) begin
            drain_all();
            case (phase)
                0: begin
                    write_reg(REG_START_MARKER, 8'h00);
                    write_reg(REG_END_MARKER, 8'hFF);
                end
                1: begin
                    write_reg(REG_START_MARKER, 8'hFF);
                    write_reg(REG_END_MARKER, 8'h00);
                    write_reg(REG_SPARE, 8'h00);
                    write_reg(REG_TOP, 8'hFF);
                end
                2: begin
                    write_reg(REG_START_MARKER, 8'h5A);
                    write_reg(REG_END_MARKER, 8'h5A);
                    // starve the result side so the input stalls on a waiting end byte
                    hold_asks++;
                end
                default: begin
                    write_reg(REG_START_MARKER, 8'($urandom));
                    write_reg(REG_END_MARKER, 8'($urandom));
                    if ($urandom_range(0, 2) == 0) begin
                        write_reg(($urandom_range(0, 1) == 0) ? REG_SPARE : REG_TOP,
                                  8'($urandom));
                    end
                end
            endcase

            if (phase == 3) begin
                // change both markers halfway through a frame
                pl       = {$urandom, $urandom};
                part_xor = '0;
                push_byte(mk_start);
                for (int i = 0; i < 4; i++) begin
                    push_byte(pl[8*i +: 8]);
                    part_xor ^= pl[8*i +: 8];
                end
                drain_all();
                write_reg(REG_END_MARKER, ~mk_end);
                write_reg(REG_START_MARKER, ~mk_start);
                for (int i = 4; i < PAYLOAD_BYTES; i++) begin
                    push_byte(pl[8*i +: 8]);
                    part_xor ^= pl[8*i +: 8];
                end
                push_byte(part_xor);
                push_byte(mk_end);
            end

            for (int f = 0; f < FRAMES_PER_RUN; f++) begin
                pl = {$urandom, $urandom};
                for (int i = 0; i < PAYLOAD_BYTES; i++) begin
                    case ($urandom_range(0, 9))
                        0: pl[8*i +: 8] = mk_start;
                        1: pl[8*i +: 8] = mk_end;
                        2: pl[8*i +: 8] = 8'h00;
                        default: ;
                    endcase
                end
                pick = $urandom_range(0, 99);
                if (pick < 65) begin
                    queue_frame(pl, FRAME_GOOD);
                end else if (pick < 77) begin
                    queue_frame(pl, FRAME_BAD_END);
                end else if (pick < 89) begin
                    queue_frame(pl, FRAME_BAD_SUM);
                end else if (pick < 94) begin
                    queue_frame(pl, FRAME_BAD_BOTH);
                end else begin
                    // cut frame: the next frame's bytes fill in the rest
                    push_byte(mk_start);
                    n = $urandom_range(0, 10);
                    for (int i = 0; i < n; i++) push_byte(8'($urandom));
                end
                if ($urandom_range(0, 4) == 0) begin
                    n = $urandom_range(1, 4);
                    for (int i = 0; i < n; i++) begin
                        b = 8'($urandom);
                        if (b == mk_start && $urandom_range(0, 3) != 0) b ^= 8'h01;
                        push_byte(b);
                    end
                end
            end
            phase++;
        end

        drain_all();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && pending_frames.size() == 0) begin
            $display("** fixed_frame_deframer_xor_check: PASSED **");
        end else begin
            $display("** fixed_frame_deframer_xor_check: FAILED **");
        end
        $finish;
    end

endmodule
